/* rtl/lcrw_pkg.sv */
// ----------------------------------------------------------------------------
// lcrw_pkg: shared definitions for the rectangular window line clipper
// coordinate widths, outcode bits and register indexes
// ----------------------------------------------------------------------------
`default_nettype none

package lcrw_pkg;

  // signed coordinate width of every field and window register
  localparam int COORD_BITS = 16;
  // width of a coordinate difference
  localparam int DIFF_BITS = COORD_BITS + 1;
  // most edge clips made on one segment
  localparam int CLIP_LIMIT = 4;

  // configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic [3:0]                   code_t;

  // outcode bits
  localparam code_t CODE_TOP    = 4'b1000;
  localparam code_t CODE_BOTTOM = 4'b0100;
  localparam code_t CODE_RIGHT  = 4'b0010;
  localparam code_t CODE_LEFT   = 4'b0001;

  // register indexes (byte address divided by four)
  localparam logic [1:0] REG_LEFT   = 2'd0;
  localparam logic [1:0] REG_BOTTOM = 2'd1;
  localparam logic [1:0] REG_RIGHT  = 2'd2;
  localparam logic [1:0] REG_TOP    = 2'd3;

  // register reset values
  localparam coord_t RST_LEFT   = coord_t'(0);
  localparam coord_t RST_BOTTOM = coord_t'(0);
  localparam coord_t RST_RIGHT  = coord_t'(799);
  localparam coord_t RST_TOP    = coord_t'(599);

endpackage

`default_nettype wire

/* rtl/line_clip_rect_window.sv */
// ----------------------------------------------------------------------------
// line_clip_rect_window: Cohen-Sutherland segment clipper
// clips one segment against a window held in four registers, using one
// shared shift-add multiply / restoring divide unit under a small sequencer
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | beat contents
//  --------+-----------+---------------------+-------------------------------
//  in_     | input     | in_valid / in_stall | start_x, start_y, end_x, end_y
//  out_    | output    | out_valid/out_stall | accepted, clipped endpoints
//  apb     | input     | psel/penable/pready | window register write / read
//
// a segment goes from its input beat to its output beat through k edge
// clips, where k (0 to 4) is the number of clips; each clip checks the
// outcodes, runs a shift-add multiply and then a restoring divide in the
// shared unit, and moves the endpoint
// in_stall is high from the accepted input beat until the result reaches the
// output register; the output register holds while out_stall is high, and a
// new segment is taken meanwhile
// rst_n is synchronous; the window returns to left 0, bottom 0, right 799,
// top 599
//
`default_nettype none

module line_clip_rect_window (
  input  wire                                clk,
  input  wire                                rst_n,
  // input beats
  input  wire                                in_valid,
  output logic                               in_stall,
  input  lcrw_pkg::coord_t                   in_start_x,
  input  lcrw_pkg::coord_t                   in_start_y,
  input  lcrw_pkg::coord_t                   in_end_x,
  input  lcrw_pkg::coord_t                   in_end_y,
  // result beats
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_accepted,
  output lcrw_pkg::coord_t                   out_clip_start_x,
  output lcrw_pkg::coord_t                   out_clip_start_y,
  output lcrw_pkg::coord_t                   out_clip_end_x,
  output lcrw_pkg::coord_t                   out_clip_end_y,
  // configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire [lcrw_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire [lcrw_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [lcrw_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  import lcrw_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CODE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  localparam int MW      = COORD_BITS;
  localparam int CNT_W   = $clog2(MW);
  localparam int ITER_W  = $clog2(CLIP_LIMIT + 1);
  localparam int UNIT_W  = MW + 2;
  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(MW - 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CLIP_LIMIT);

  // window registers
  coord_t win_left_r, win_bottom_r, win_right_r, win_top_r;

  // working endpoints
  coord_t x1_r, y1_r, x2_r, y2_r;
  coord_t x1_nxt, y1_nxt, x2_nxt, y2_nxt;

  logic [2:0]        state_r, state_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              ok_r, ok_nxt;

  // clip bookkeeping
  logic   neg_r, neg_nxt;       // sign of the interpolated step
  logic   axis_x_r, axis_x_nxt; // 1: new x is interpolated, y sits on the edge
  logic   move2_r, move2_nxt;   // 1: the end point moves
  coord_t edge_r, edge_nxt;

  // shared unit registers
  logic [MW:0]   acc_r, acc_nxt;
  logic [MW-1:0] low_r, low_nxt;
  logic [MW-1:0] opa_r, opa_nxt;
  logic [MW-1:0] den_r, den_nxt;

  // output register
  logic   out_valid_r, out_valid_nxt;
  logic   out_acc_r, out_acc_nxt;
  coord_t out_sx_r, out_sy_r, out_ex_r, out_ey_r;
  coord_t out_sx_nxt, out_sy_nxt, out_ex_nxt, out_ey_nxt;

  function automatic code_t outcode(input coord_t x, input coord_t y,
                                    input coord_t l, input coord_t b,
                                    input coord_t r, input coord_t t);
    code_t c;
    c = '0;
    if (y > t)      c = c | CODE_TOP;
    else if (y < b) c = c | CODE_BOTTOM;
    if (x > r)      c = c | CODE_RIGHT;
    else if (x < l) c = c | CODE_LEFT;
    return c;
  endfunction

  function automatic logic [MW-1:0] mag_of(input diff_t v);
    diff_t n;
    n = (v < 0) ? -v : v;
    return n[MW-1:0];
  endfunction

  // ---------------------------------------------------------------- apb port
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    case (reg_idx)
      REG_LEFT:   prdata = APB_DATA_BITS'(win_left_r);
      REG_BOTTOM: prdata = APB_DATA_BITS'(win_bottom_r);
      REG_RIGHT:  prdata = APB_DATA_BITS'(win_right_r);
      REG_TOP:    prdata = APB_DATA_BITS'(win_top_r);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_left_r   <= RST_LEFT;
      win_bottom_r <= RST_BOTTOM;
      win_right_r  <= RST_RIGHT;
      win_top_r    <= RST_TOP;
    end else if (wr_en) begin
      case (reg_idx)
        REG_LEFT:   win_left_r   <= pwdata[COORD_BITS-1:0];
        REG_BOTTOM: win_bottom_r <= pwdata[COORD_BITS-1:0];
        REG_RIGHT:  win_right_r  <= pwdata[COORD_BITS-1:0];
        REG_TOP:    win_top_r    <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- outcode and edges
  code_t c1, c2, co;
  diff_t dx, dy, num, dd, den;
  logic  win_bad;

  always_comb begin
    c1 = outcode(x1_r, y1_r, win_left_r, win_bottom_r, win_right_r, win_top_r);
    c2 = outcode(x2_r, y2_r, win_left_r, win_bottom_r, win_right_r, win_top_r);
    co = (c1 != '0) ? c1 : c2;
    // an inverted window can never hold a point, so every segment is rejected
    win_bad = (win_left_r > win_right_r) || (win_bottom_r > win_top_r);
    dx = DIFF_BITS'(x2_r) - DIFF_BITS'(x1_r);
    dy = DIFF_BITS'(y2_r) - DIFF_BITS'(y1_r);
    if ((co & CODE_TOP) != '0) begin
      num = DIFF_BITS'(win_top_r) - DIFF_BITS'(y1_r);
      dd  = dx;
      den = dy;
    end else if ((co & CODE_BOTTOM) != '0) begin
      num = DIFF_BITS'(win_bottom_r) - DIFF_BITS'(y1_r);
      dd  = dx;
      den = dy;
    end else if ((co & CODE_LEFT) != '0) begin
      num = DIFF_BITS'(win_left_r) - DIFF_BITS'(x1_r);
      dd  = dy;
      den = dx;
    end else begin
      num = DIFF_BITS'(win_right_r) - DIFF_BITS'(x1_r);
      dd  = dy;
      den = dx;
    end
  end

  // --------------------------------------------------------------- shared unit
  // multiply: shift-add of opa into acc:low, low starts as the multiplier
  // divide: restoring, acc holds the remainder, quotient bits shift into low
  logic [MW:0]     div_shift;
  logic [UNIT_W-1:0] unit_a, unit_b, unit_sum;
  logic            unit_cin;

  assign div_shift = {acc_r[MW-1:0], low_r[MW-1]};

  always_comb begin
    if (state_r == ST_DIV) begin
      unit_a   = {1'b0, div_shift};
      unit_b   = ~{2'b00, den_r};
      unit_cin = 1'b1;
    end else begin
      unit_a   = {1'b0, acc_r};
      unit_b   = low_r[0] ? {2'b00, opa_r} : '0;
      unit_cin = 1'b0;
    end
    unit_sum = unit_a + unit_b + UNIT_W'(unit_cin);
  end

  // ------------------------------------------------------- endpoint update
  coord_t base_c;
  diff_t  step_res;
  coord_t new_c;

  always_comb begin
    base_c   = axis_x_r ? x1_r : y1_r;
    step_res = neg_r ? (DIFF_BITS'(base_c) - diff_t'({1'b0, low_r}))
                     : (DIFF_BITS'(base_c) + diff_t'({1'b0, low_r}));
    new_c    = step_res[COORD_BITS-1:0];
  end

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    iter_nxt      = iter_r;
    cnt_nxt       = cnt_r;
    ok_nxt        = ok_r;
    neg_nxt       = neg_r;
    axis_x_nxt    = axis_x_r;
    move2_nxt     = move2_r;
    edge_nxt      = edge_r;
    acc_nxt       = acc_r;
    low_nxt       = low_r;
    opa_nxt       = opa_r;
    den_nxt       = den_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_acc_nxt   = out_acc_r;
    out_sx_nxt    = out_sx_r;
    out_sy_nxt    = out_sy_r;
    out_ex_nxt    = out_ex_r;
    out_ey_nxt    = out_ey_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          x1_nxt    = in_start_x;
          y1_nxt    = in_start_y;
          x2_nxt    = in_end_x;
          y2_nxt    = in_end_y;
          iter_nxt  = '0;
          state_nxt = ST_CODE;
        end
      end
      ST_CODE: begin
        if (win_bad) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end else if ((c1 | c2) == '0) begin
          ok_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end else if (((c1 & c2) != '0) || (iter_r == ITER_LAST)) begin
          ok_nxt    = 1'b0;
          state_nxt = ST_DONE;
        end else begin
          move2_nxt  = (c1 == '0);
          axis_x_nxt = ((co & (CODE_TOP | CODE_BOTTOM)) != '0);
          if ((co & CODE_TOP) != '0)         edge_nxt = win_top_r;
          else if ((co & CODE_BOTTOM) != '0) edge_nxt = win_bottom_r;
          else if ((co & CODE_LEFT) != '0)   edge_nxt = win_left_r;
          else                               edge_nxt = win_right_r;
          neg_nxt   = ((num < 0) != (dd < 0)) != (den < 0);
          acc_nxt   = '0;
          low_nxt   = mag_of(num);
          opa_nxt   = mag_of(dd);
          den_nxt   = mag_of(den);
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt = {1'b0, unit_sum[MW:1]};
        low_nxt = {unit_sum[0], low_r[MW-1:1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // borrow out of the subtract means the trial does not fit
        if (unit_sum[UNIT_W-1]) acc_nxt = div_shift;
        else                    acc_nxt = unit_sum[MW:0];
        low_nxt = {low_r[MW-2:0], ~unit_sum[UNIT_W-1]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (move2_r) begin
          x2_nxt = axis_x_r ? new_c : edge_r;
          y2_nxt = axis_x_r ? edge_r : new_c;
        end else begin
          x1_nxt = axis_x_r ? new_c : edge_r;
          y1_nxt = axis_x_r ? edge_r : new_c;
        end
        iter_nxt  = iter_r + 1'b1;
        state_nxt = ST_CODE;
      end
      ST_DONE: begin
        // wait here while the previous result still sits stalled
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_acc_nxt   = ok_r;
          out_sx_nxt    = ok_r ? x1_r : '0;
          out_sy_nxt    = ok_r ? y1_r : '0;
          out_ex_nxt    = ok_r ? x2_r : '0;
          out_ey_nxt    = ok_r ? y2_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      iter_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iter_r      <= iter_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r      <= ok_nxt;
    neg_r     <= neg_nxt;
    axis_x_r  <= axis_x_nxt;
    move2_r   <= move2_nxt;
    edge_r    <= edge_nxt;
    acc_r     <= acc_nxt;
    low_r     <= low_nxt;
    opa_r     <= opa_nxt;
    den_r     <= den_nxt;
    x1_r      <= x1_nxt;
    y1_r      <= y1_nxt;
    x2_r      <= x2_nxt;
    y2_r      <= y2_nxt;
    out_acc_r <= out_acc_nxt;
    out_sx_r  <= out_sx_nxt;
    out_sy_r  <= out_sy_nxt;
    out_ex_r  <= out_ex_nxt;
    out_ey_r  <= out_ey_nxt;
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_accepted     = out_acc_r;
  assign out_clip_start_x = out_sx_r;
  assign out_clip_start_y = out_sy_r;
  assign out_clip_end_x   = out_ex_r;
  assign out_clip_end_y   = out_ey_r;

endmodule

`default_nettype wire

/* test/lcrw_checker.sv */
// ----------------------------------------------------------------------------
// lcrw_checker: result predictor and scoreboard for line_clip_rect_window
// follows window register writes on the configuration port, works out the
// clipped segment for every input beat and compares each result beat with
// the oldest expectation, field by field
// ----------------------------------------------------------------------------

module lcrw_checker (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire                                in_stall,
  input  lcrw_pkg::coord_t                   in_start_x,
  input  lcrw_pkg::coord_t                   in_start_y,
  input  lcrw_pkg::coord_t                   in_end_x,
  input  lcrw_pkg::coord_t                   in_end_y,
  input  wire                                out_valid,
  input  wire                                out_stall,
  input  wire                                out_accepted,
  input  lcrw_pkg::coord_t                   out_clip_start_x,
  input  lcrw_pkg::coord_t                   out_clip_start_y,
  input  lcrw_pkg::coord_t                   out_clip_end_x,
  input  lcrw_pkg::coord_t                   out_clip_end_y,
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire                                pready,
  input  wire [lcrw_pkg::APB_ADDR_BITS-1:0]  paddr,
  input  wire [lcrw_pkg::APB_DATA_BITS-1:0]  pwdata,
  input  wire [lcrw_pkg::APB_DATA_BITS-1:0]  prdata,
  output int                                 err_count,
  output int                                 pending
);

  import lcrw_pkg::*;

  typedef struct packed {
    logic   accepted;
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } clip_beat_t;

  longint     win_l = RST_LEFT;
  longint     win_b = RST_BOTTOM;
  longint     win_r = RST_RIGHT;
  longint     win_t = RST_TOP;
  clip_beat_t clipped_q[$];

  initial begin
    err_count = 0;
    pending   = 0;
  end

  function automatic code_t region_code(longint x, longint y);
    code_t c;
    c = '0;
    if (y > win_t) c |= CODE_TOP;
    else if (y < win_b) c |= CODE_BOTTOM;
    if (x > win_r) c |= CODE_RIGHT;
    else if (x < win_l) c |= CODE_LEFT;
    return c;
  endfunction

  // base + num * d / den, quotient truncated toward zero
  function automatic longint edge_cross(longint base, longint num, longint d, longint den);
    if (den == 0) return base;
    return base + (num * d) / den;
  endfunction

  function automatic clip_beat_t clip_against_window(coord_t sx, coord_t sy,
                                                     coord_t ex, coord_t ey);
    longint     x1, y1, x2, y2, dx, dy, nx, ny;
    code_t      c1, c2, co;
    bit         done, in_win;
    clip_beat_t r;
    x1 = sx;
    y1 = sy;
    x2 = ex;
    y2 = ey;
    done = 1'b0;
    in_win = 1'b0;
    for (int n = 0; n <= CLIP_LIMIT && !done; n++) begin
      c1 = region_code(x1, y1);
      c2 = region_code(x2, y2);
      if ((c1 | c2) == 0) begin
        in_win = 1'b1;
        done = 1'b1;
      end else if ((c1 & c2) != 0 || n == CLIP_LIMIT) begin
        done = 1'b1;
      end else begin
        co = (c1 != 0) ? c1 : c2;
        dx = x2 - x1;
        dy = y2 - y1;
        if ((co & CODE_TOP) != 0) begin
          nx = edge_cross(x1, win_t - y1, dx, dy);
          ny = win_t;
        end else if ((co & CODE_BOTTOM) != 0) begin
          nx = edge_cross(x1, win_b - y1, dx, dy);
          ny = win_b;
        end else if ((co & CODE_LEFT) != 0) begin
          ny = edge_cross(y1, win_l - x1, dy, dx);
          nx = win_l;
        end else begin
          ny = edge_cross(y1, win_r - x1, dy, dx);
          nx = win_r;
        end
        if (c1 != 0) begin
          x1 = nx;
          y1 = ny;
        end else begin
          x2 = nx;
          y2 = ny;
        end
      end
    end
    r.accepted = in_win;
    r.sx = in_win ? coord_t'(x1) : '0;
    r.sy = in_win ? coord_t'(y1) : '0;
    r.ex = in_win ? coord_t'(x2) : '0;
    r.ey = in_win ? coord_t'(y2) : '0;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [COORD_BITS-1:0] want_v,
                             input logic [COORD_BITS-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, what,
               $signed(want_v), $signed(got_v));
      err_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    clip_beat_t want;
    longint     wval;
    if (!rst_n) begin
      win_l = RST_LEFT;
      win_b = RST_BOTTOM;
      win_r = RST_RIGHT;
      win_t = RST_TOP;
      clipped_q.delete();
      pending = 0;
    end else begin
      // register access phase
      if (psel && penable && pready) begin
        wval = longint'(coord_t'(pwdata[COORD_BITS-1:0]));
        case (paddr[APB_ADDR_BITS-1:2])
          REG_LEFT: if (pwrite) win_l = wval;
            else check_field("win_left readback", coord_t'(win_l), prdata[COORD_BITS-1:0]);
          REG_BOTTOM: if (pwrite) win_b = wval;
            else check_field("win_bottom readback", coord_t'(win_b), prdata[COORD_BITS-1:0]);
          REG_RIGHT: if (pwrite) win_r = wval;
            else check_field("win_right readback", coord_t'(win_r), prdata[COORD_BITS-1:0]);
          REG_TOP: if (pwrite) win_t = wval;
            else check_field("win_top readback", coord_t'(win_t), prdata[COORD_BITS-1:0]);
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        clipped_q.push_back(clip_against_window(in_start_x, in_start_y, in_end_x, in_end_y));
      if (out_valid && !out_stall) begin
        if (clipped_q.size() == 0) begin
          $display("%0t: result beat with no segment outstanding (accepted %0b)",
                   $time, out_accepted);
          err_count++;
        end else begin
          want = clipped_q.pop_front();
          check_field("accepted", COORD_BITS'(want.accepted), COORD_BITS'(out_accepted));
          check_field("clip_start_x", want.sx, out_clip_start_x);
          check_field("clip_start_y", want.sy, out_clip_start_y);
          check_field("clip_end_x", want.ex, out_clip_end_x);
          check_field("clip_end_y", want.ey, out_clip_end_y);
        end
      end
      pending = clipped_q.size();
    end
  end

endmodule

/* test/tb_line_clip_rect_window.sv */
// ----------------------------------------------------------------------------
// tb_line_clip_rect_window: regression for the segment clipper
// drives directed and random segments through several window settings with
// random idle gaps on both channels; lcrw_checker predicts and compares
// ----------------------------------------------------------------------------

module tb_line_clip_rect_window;

  import lcrw_pkg::*;

  // generous bound: covers the slowest segment plus worst gaps on both sides
  localparam int CYCLE_LIMIT  = 2_000_000;
  // quiet time after the last result
  localparam int DRAIN_CYCLES = 600;
  localparam int PHASE_ITEMS  = 66;
  localparam int NUM_PHASES   = 8;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  coord_t                   in_start_x, in_start_y, in_end_x, in_end_y;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_accepted;
  coord_t                   out_clip_start_x, out_clip_start_y;
  coord_t                   out_clip_end_x, out_clip_end_y;
  logic                     psel, penable, pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  int                       err_count;
  int                       pending;

  // no idling on either side while set
  bit calm = 1'b0;
  int stall_left = 0;
  int cycle_count;
  // window as last written, used only to aim the random segments
  int cur_l = RST_LEFT;
  int cur_b = RST_BOTTOM;
  int cur_r = RST_RIGHT;
  int cur_t = RST_TOP;

  line_clip_rect_window i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_clip_start_x (out_clip_start_x),
    .out_clip_start_y (out_clip_start_y),
    .out_clip_end_x   (out_clip_end_x),
    .out_clip_end_y   (out_clip_end_y),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  lcrw_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_start_x       (in_start_x),
    .in_start_y       (in_start_y),
    .in_end_x         (in_end_x),
    .in_end_y         (in_end_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_accepted     (out_accepted),
    .out_clip_start_x (out_clip_start_x),
    .out_clip_start_y (out_clip_start_y),
    .out_clip_end_x   (out_clip_end_x),
    .out_clip_end_y   (out_clip_end_y),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .pready           (pready),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .err_count        (err_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("line_clip_rect_window regression: fail");
    $finish;
  end

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // idle length: picked from one of two ranges, the long hold now and then
  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return rand_between(1, 3);
    return rand_between(10, 60);
  endfunction

  function automatic int clamp_coord(int v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return v;
  endfunction

  // one coordinate aimed at the window span [a, b] on that axis, with some
  // fully random values and some landing right on or next to an edge
  function automatic int pick_near(int a, int b);
    int lo, hi, span, r;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    span = (hi - lo) / 2 + 16;
    r = $urandom_range(0, 99);
    if (r < 12) return int'(coord_t'($urandom));
    if (r < 24) begin
      case ($urandom_range(0, 5))
        0: return -32768;
        1: return 32767;
        2: return lo;
        3: return hi;
        4: return clamp_coord(lo - 1);
        default: return clamp_coord(hi + 1);
      endcase
    end
    return clamp_coord(rand_between(lo - span, hi + span));
  endfunction

  // result side back-pressure, independent of the input side
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (!calm && $urandom_range(0, 3) == 0) begin
      stall_left <= pick_gap() - 1;
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // one input beat; valid stays high after acceptance so back-to-back beats
  // need no second assignment in the same step
  task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
    int gap;
    gap = (calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_start_x <= coord_t'(sx);
    in_start_y <= coord_t'(sy);
    in_end_x   <= coord_t'(ex);
    in_end_y   <= coord_t'(ey);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // random segment shapes: general, horizontal, vertical and single points
  task automatic send_random_segment();
    int sx, sy, ex, ey, shape;
    sx = pick_near(cur_l, cur_r);
    sy = pick_near(cur_b, cur_t);
    ex = pick_near(cur_l, cur_r);
    ey = pick_near(cur_b, cur_t);
    shape = $urandom_range(0, 99);
    if (shape < 15) begin
      ey = sy;
    end else if (shape < 25) begin
      ex = sx;
    end else if (shape < 30) begin
      ex = sx;
      ey = sy;
    end
    send_segment(sx, sy, ex, ey);
  endtask

  // stop sending and wait until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // setup cycle, access cycle, then an idle cycle so psel never drops and
  // rises in the same step; upper data bits carry noise
  task automatic apb_xfer(input bit wr, input logic [1:0] idx, input coord_t val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= APB_ADDR_BITS'({idx, 2'b00});
    pwdata  <= {16'($urandom), val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_window();
    apb_xfer(1'b0, REG_LEFT, '0);
    apb_xfer(1'b0, REG_BOTTOM, '0);
    apb_xfer(1'b0, REG_RIGHT, '0);
    apb_xfer(1'b0, REG_TOP, '0);
  endtask

  task automatic set_window(input int l, input int b, input int r, input int t);
    cur_l = l;
    cur_b = b;
    cur_r = r;
    cur_t = t;
    apb_xfer(1'b1, REG_LEFT, coord_t'(l));
    apb_xfer(1'b1, REG_BOTTOM, coord_t'(b));
    apb_xfer(1'b1, REG_RIGHT, coord_t'(r));
    apb_xfer(1'b1, REG_TOP, coord_t'(t));
    read_window();
  endtask

  initial begin
    int l, b;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_start_x <= '0;
    in_start_y <= '0;
    in_end_x   <= '0;
    in_end_y   <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset window values should read back before anything is written
    read_window();

    // directed segments against the reset window 0..799 x 0..599
    send_segment(100, 100, 700, 500);          // fully inside
    send_segment(10, 700, 500, 900);           // both above: trivial reject
    send_segment(400, 300, 400, 1000);         // vertical through top
    send_segment(200, -50, 300, 100);          // through bottom
    send_segment(-100, 300, 50, 320);          // through left
    send_segment(700, 100, 900, 200);          // through right
    send_segment(-500, 250, 1500, 250);        // horizontal across left and right
    send_segment(30, -1000, 30, 2000);         // vertical across bottom and top
    send_segment(-100, -100, 900, 700);        // diagonal, clips at both ends
    send_segment(-60, 560, 40, 660);           // passes outside the corner
    send_segment(400, 300, 400, 300);          // point inside
    send_segment(-1, -1, -1, -1);              // point just outside
    send_segment(-32768, -32768, 32767, 32767);
    send_segment(32767, -32768, -32768, 32767);
    send_segment(-32768, -32768, -32768, -32768);
    send_segment(32767, 32767, 32767, 32767);
    send_segment(0, 0, 799, 599);              // endpoints on the edges
    send_segment(800, 600, -1, -1);            // both just outside, across
    send_segment(400, 300, 400, -32768);       // only the second endpoint moves
    send_segment(50, 320, -100, 300);          // inside to left
    send_segment(0, -32768, 799, 32767);       // steep, large multiply
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: ;  // stay on the reset window
        1: begin
          l = rand_between(-3000, 1000);
          b = rand_between(-3000, 1000);
          set_window(l, b, l + rand_between(0, 4000), b + rand_between(0, 4000));
        end
        2: set_window(-32768, -32768, 32767, 32767);
        3: begin
          // single-point window
          l = rand_between(-100, 100);
          b = rand_between(-100, 100);
          set_window(l, b, l, b);
        end
        4: begin
          // inverted window, left above right and bottom above top
          l = rand_between(0, 500);
          b = rand_between(0, 500);
          set_window(l, b, l - rand_between(1, 500), b - rand_between(1, 500));
        end
        5: set_window(32000, 32000, 32767, 32767);
        6: set_window(-32768, -32768, -32000, -32000);
        default: set_window(RST_LEFT, RST_BOTTOM, RST_RIGHT, RST_TOP);
      endcase
      // one phase always runs with no idling, others by chance
      calm = (ph == 2) || ($urandom_range(0, 4) == 0);
      repeat (PHASE_ITEMS) send_random_segment();
      drain();
      calm = 1'b0;
    end

    // catch any stray result beats
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending == 0)
      $display("line_clip_rect_window regression: pass");
    else
      $display("line_clip_rect_window regression: fail");
    $finish;
  end

endmodule

/* line_clip_rect_window.f */
rtl/lcrw_pkg.sv
rtl/line_clip_rect_window.sv
test/lcrw_checker.sv
test/tb_line_clip_rect_window.sv
